// ----- rtl/core/text_stream_line_filter_assert.svh -----
// assertion macros for the text stream line filter
// no dependencies; included by the modules that carry assertions
`ifndef TEXT_STREAM_LINE_FILTER_ASSERT_SVH
`define TEXT_STREAM_LINE_FILTER_ASSERT_SVH
`ifndef SYNTH
`define TSLF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tslf assertion failed");
`define TSLF_CHECK(lbl, prop) \
  `TSLF_ASSERT(lbl, clk, rst_n, prop)
`else
`define TSLF_ASSERT(lbl, clk, rstn, prop)
`define TSLF_CHECK(lbl, prop)
`endif
`endif

// ----- rtl/core/tslf_pkg.sv -----
// shared types, constants and helpers of the text stream line filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package tslf_pkg;

  localparam int NUMBER_DIGITS_DEF = 6;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd5;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_I       = 8'h49;
  localparam logic [7:0] CH_M       = 8'h4d;
  localparam logic [7:0] CH_CARET   = 8'h5e;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] META_LO    = 8'd128;
  localparam logic [7:0] META_HI    = 8'd159;
  localparam logic [7:0] NP_OFFSET  = 8'd64;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_tabs;
    logic show_nonprinting;
    logic show_ends;
  } cfg_t;

  // one classified transaction as handed from front to back
  typedef struct packed {
    logic       pre;
    logic       pre_blank;
    logic       dollar;
    logic       mdash;
    logic       caret;
    logic [7:0] ch;
  } desc_t;

  typedef enum logic [2:0] {
    PH_PRE,
    PH_DOLLAR,
    PH_MCHAR,
    PH_DASH,
    PH_CARET,
    PH_BYTE
  } phase_t;

  // first phase at or after p that the transaction needs
  function automatic phase_t first_from(desc_t d, phase_t p);
    phase_t r;
    r = PH_BYTE;
    if (p <= PH_CARET && d.caret) r = PH_CARET;
    if (p <= PH_MCHAR && d.mdash) r = PH_MCHAR;
    if (p <= PH_DOLLAR && d.dollar) r = PH_DOLLAR;
    if (p <= PH_PRE && d.pre) r = PH_PRE;
    return r;
  endfunction

endpackage

// ----- rtl/core/text_stream_line_filter.sv -----
// Text stream line filter: each input byte yields one to NUMBER_DIGITS+5 output bytes
// (line number or blank padding with tab, '$', "M-", '^', then the rendered byte);
// a squeezed blank line yields none. The back sequencer emits one output byte per
// cycle while the output is not stalled. Bytes pass through the descriptor queue,
// the back descriptor registers and the registered output stage. Input is taken
// every cycle while the QUEUE_DEPTH-entry descriptor queue has room. The user must
// write options via the cfg port only while the block is idle; this is not enforced.
// depends on tslf_pkg, tslf_front, tslf_queue and tslf_back
`timescale 1ns / 1ps
module text_stream_line_filter #(
  parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = tslf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tslf_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [tslf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tslf_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tslf_pkg::out_item_t                 out_data
);
  import tslf_pkg::*;

  localparam int DW = NUMBER_DIGITS * 4;
  localparam int QW = $bits(desc_t) + DW;

  cfg_t          cfg_r, cfg_nxt;
  logic          push, q_full, q_valid, q_pop;
  desc_t         push_desc, q_desc;
  logic [DW-1:0] push_digits, q_digits;
  logic [QW-1:0] q_out;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_NUMBER_NONBLANK:  cfg_nxt.number_nonblank  = cfg_wdata[0];
        CFG_NUMBER_ALL:       cfg_nxt.number_all       = cfg_wdata[0];
        CFG_SQUEEZE_BLANK:    cfg_nxt.squeeze_blank    = cfg_wdata[0];
        CFG_SHOW_TABS:        cfg_nxt.show_tabs        = cfg_wdata[0];
        CFG_SHOW_NONPRINTING: cfg_nxt.show_nonprinting = cfg_wdata[0];
        CFG_SHOW_ENDS:        cfg_nxt.show_ends        = cfg_wdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tslf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc),
    .push_digits(push_digits)
  );

  tslf_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_desc, push_digits}),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_data (q_out)
  );

  assign q_desc   = q_out[QW-1 -: $bits(desc_t)];
  assign q_digits = q_out[DW-1:0];

  tslf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_desc   (q_desc),
    .q_digits (q_digits),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ----- rtl/core/tslf_front.sv -----
// front part: accepts input bytes, tracks line state and the bcd line counter,
// classifies each byte into a descriptor; depends on tslf_pkg
`timescale 1ns / 1ps
module tslf_front #(
  parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tslf_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tslf_pkg::in_item_t           in_data,
  input  logic                         q_full,
  output logic                         push,
  output tslf_pkg::desc_t              push_desc,
  output logic [NUMBER_DIGITS*4-1:0]   push_digits
);
  import tslf_pkg::*;

  localparam int DW = NUMBER_DIGITS * 4;

  logic          prev_nl_r, prev_nl_nxt;
  logic          blank_r, blank_nxt;
  logic [DW-1:0] count_r, count_nxt;

  logic          accept;
  logic          pnl, blank, cur_nl, squeeze, num_all, do_num, pad;
  logic [DW-1:0] count, count_inc;
  logic          carry;
  logic [7:0]    c;
  logic          caret, mdash;

  // new-file marker restarts line state
  always_comb begin
    pnl   = in_data.new_file ? 1'b1 : prev_nl_r;
    blank = in_data.new_file ? 1'b0 : blank_r;
    count = in_data.new_file ? DW'(1) : count_r;
  end

  // saturating bcd increment
  always_comb begin
    count_inc = count;
    carry     = (count != {NUMBER_DIGITS{4'h9}});
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      if (carry) begin
        if (count[4*k +: 4] == 4'h9) begin
          count_inc[4*k +: 4] = 4'h0;
        end else begin
          count_inc[4*k +: 4] = count[4*k +: 4] + 4'h1;
          carry = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cur_nl  = (in_data.in_byte == CH_NL);
    num_all = cfg.number_all && !cfg.number_nonblank;
    squeeze = cur_nl && pnl && cfg.squeeze_blank && blank;
    do_num  = !squeeze && ((cfg.number_nonblank && pnl && !cur_nl) || (num_all && pnl));
    pad     = !squeeze && cur_nl && cfg.show_ends && cfg.number_nonblank && pnl;
  end

  // character rendering
  always_comb begin
    c     = in_data.in_byte;
    caret = 1'b0;
    mdash = 1'b0;
    if (cfg.show_tabs && c == CH_TAB) begin
      caret = 1'b1;
      c     = CH_I;
    end
    if (cfg.show_nonprinting) begin
      if (c inside {[META_LO:META_HI]}) mdash = 1'b1;
      if ((c < CH_SPACE && c != CH_NL && c != CH_TAB) || c == CH_DEL) caret = 1'b1;
      if ((c < CH_SPACE || c inside {[CH_DEL:META_HI]}) && c != CH_NL && c != CH_TAB) begin
        c = (c > CH_TILDE) ? (c - NP_OFFSET) : (c + NP_OFFSET);
      end
    end
  end

  always_comb begin
    in_stall            = q_full;
    accept              = in_valid && !q_full;
    push                = accept && !squeeze;
    push_desc.pre       = do_num || pad;
    push_desc.pre_blank = pad;
    push_desc.dollar    = cfg.show_ends && cur_nl;
    push_desc.mdash     = mdash;
    push_desc.caret     = caret;
    push_desc.ch        = c;
    push_digits         = count;
  end

  always_comb begin
    prev_nl_nxt = prev_nl_r;
    blank_nxt   = blank_r;
    count_nxt   = count_r;
    if (accept) begin
      prev_nl_nxt = cur_nl;
      blank_nxt   = pnl && cur_nl;
      count_nxt   = do_num ? count_inc : count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_nl_r <= 1'b1;
      blank_r   <= 1'b0;
      count_r   <= DW'(1);
    end else begin
      prev_nl_r <= prev_nl_nxt;
      blank_r   <= blank_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/tslf_queue.sv -----
// short descriptor queue between front and back parts
// register array with first-word fall-through read; uses the assertion macros
`timescale 1ns / 1ps
`include "text_stream_line_filter_assert.svh"
module tslf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tslf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);
  import tslf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    full     = (cnt_r == CW'(DEPTH));
    valid    = (cnt_r != '0);
    pop_data = mem_r[rd_ptr_r];
    do_push  = push && !full;
    do_pop   = pop && valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop) rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  `TSLF_ASSERT(a_cnt_up, clk, rst_n, do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
  `TSLF_ASSERT(a_cnt_down, clk, rst_n, do_pop && !do_push |=> cnt_r == $past(cnt_r) - 1'b1)

endmodule

// ----- rtl/core/tslf_back.sv -----
// back part: sequences a descriptor into output bytes, one per unstalled cycle,
// into a registered output stage; depends on tslf_pkg and the assertion macros
`timescale 1ns / 1ps
`include "text_stream_line_filter_assert.svh"
module tslf_back #(
  parameter int NUMBER_DIGITS = tslf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  tslf_pkg::desc_t            q_desc,
  input  logic [NUMBER_DIGITS*4-1:0] q_digits,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tslf_pkg::out_item_t        out_data
);
  import tslf_pkg::*;

  localparam int DW    = NUMBER_DIGITS * 4;
  localparam int CNT_W = $clog2(NUMBER_DIGITS + 1);

  logic             cur_valid_r, cur_valid_nxt;
  phase_t           phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  desc_t            desc_r, desc_nxt;
  logic [DW-1:0]    sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             seen_r, seen_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic       adv, emit, is_last, at_tab;
  logic [3:0] top;
  logic [7:0] ob;
  phase_t     ph_after;

  always_comb begin
    adv     = !out_valid_r || !out_stall;
    emit    = cur_valid_r && adv;
    top     = sh_r[DW-1 -: 4];
    at_tab  = (cnt_r == CNT_W'(NUMBER_DIGITS));
    ob      = desc_r.ch;
    is_last = 1'b0;
    ph_after = phase_r;
    case (phase_r)
      PH_PRE: begin
        if (at_tab) begin
          ob       = CH_TAB;
          ph_after = first_from(desc_r, PH_DOLLAR);
        end else if (desc_r.pre_blank ||
                     (!seen_r && top == 4'h0 && cnt_r != CNT_W'(NUMBER_DIGITS - 1))) begin
          ob = CH_SPACE;
        end else begin
          ob = CH_ZERO | {4'h0, top};
        end
      end
      PH_DOLLAR: begin
        ob       = CH_DOLLAR;
        ph_after = first_from(desc_r, PH_MCHAR);
      end
      PH_MCHAR: begin
        ob       = CH_M;
        ph_after = PH_DASH;
      end
      // the meta prefix always carries its caret
      PH_DASH: begin
        ob       = CH_DASH;
        ph_after = PH_CARET;
      end
      PH_CARET: begin
        ob       = CH_CARET;
        ph_after = PH_BYTE;
      end
      PH_BYTE: begin
        ob      = desc_r.ch;
        is_last = 1'b1;
      end
      default: begin
        ob      = desc_r.ch;
        is_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    q_pop         = q_valid && (!cur_valid_r || (emit && is_last));
    cur_valid_nxt = cur_valid_r;
    phase_nxt     = phase_r;
    desc_nxt      = desc_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      phase_nxt = ph_after;
      if (phase_r == PH_PRE && !at_tab) begin
        cnt_nxt  = cnt_r + 1'b1;
        sh_nxt   = sh_r << 4;
        seen_nxt = seen_r || (top != 4'h0);
      end
      if (is_last) cur_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      desc_nxt      = q_desc;
      sh_nxt        = q_digits;
      cnt_nxt       = '0;
      seen_nxt      = 1'b0;
      phase_nxt     = first_from(q_desc, PH_PRE);
    end
    if (adv) begin
      out_valid_nxt         = cur_valid_r;
      out_data_nxt.out_byte = ob;
      out_data_nxt.last     = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= PH_BYTE;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    seen_r     <= seen_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TSLF_CHECK(a_pop_loads, q_pop |=> cur_valid_r)
  `TSLF_CHECK(a_emit_shows, emit |=> out_valid_r)
  `TSLF_CHECK(a_digit_range, cur_valid_r && phase_r == PH_PRE |-> cnt_r <= CNT_W'(NUMBER_DIGITS))

endmodule

// ----- tb/tb_text_stream_line_filter.sv -----
// testbench for text_stream_line_filter: directed and random text streams with a
// self-checking rendering predictor, random stalls on the output and idle gaps on the input
// depends on tslf_pkg and text_stream_line_filter
`timescale 1ns / 1ps
module tb_text_stream_line_filter;
  import tslf_pkg::*;

  localparam int DIGITS = NUMBER_DIGITS_DEF;
  localparam int LINE_MAX = 10 ** DIGITS - 1;
  localparam int CARRY_LINES = 12;
  localparam int SETTLE = 16;
  localparam int STUCK_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  cfg_t mode;
  logic [7:0] last_char;
  logic [19:0] line_no;
  bit blank_run;
  out_item_t rendered_q[$];

  bit quiet;
  int errors;
  int stall_left;
  int stuck_cycles;

  text_stream_line_filter #(.NUMBER_DIGITS(DIGITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void put(logic [7:0] b);
    out_item_t r;
    r.out_byte = b;
    r.last = 1'b0;
    rendered_q.push_back(r);
  endfunction

  function automatic void put_line_number();
    logic [7:0] digit[DIGITS];
    int unsigned v;
    int i;
    v = {12'd0, line_no};
    for (i = DIGITS - 1; i >= 0; i--) begin
      digit[i] = (i == DIGITS - 1 || v != 0) ? CH_ZERO + 8'(v % 10) : CH_SPACE;
      v = v / 10;
    end
    for (i = 0; i < DIGITS; i++) put(digit[i]);
    put(CH_TAB);
    if (line_no < LINE_MAX) line_no++;
  endfunction

  function automatic void render(in_item_t it);
    logic [7:0] c;
    bit prev_nl;
    bit cur_nl;
    bit num_all;
    out_item_t tail;
    c = it.in_byte;
    if (it.new_file) begin
      last_char = CH_NL;
      line_no = 20'd1;
      blank_run = 1'b0;
    end
    prev_nl = (last_char == CH_NL);
    cur_nl = (c == CH_NL);
    num_all = mode.number_all && !mode.number_nonblank;
    // squeezed empty line
    if (cur_nl && prev_nl && mode.squeeze_blank && blank_run) return;
    blank_run = prev_nl && cur_nl;
    if ((mode.number_nonblank && prev_nl && !cur_nl) || (num_all && prev_nl))
      put_line_number();
    if (mode.show_tabs && c == CH_TAB) begin
      put(CH_CARET);
      c = CH_I;
    end
    if (mode.show_ends && cur_nl) begin
      if (mode.number_nonblank && prev_nl) begin
        repeat (DIGITS) put(CH_SPACE);
        put(CH_TAB);
      end
      put(CH_DOLLAR);
    end
    if (mode.show_nonprinting) begin
      if (c >= META_LO && c <= META_HI) begin
        put(CH_M);
        put(CH_DASH);
        put(CH_CARET);
      end
      if ((c < CH_SPACE && c != CH_NL && c != CH_TAB) || c == CH_DEL) put(CH_CARET);
      if ((c < CH_SPACE || (c > CH_TILDE && c <= META_HI)) && c != CH_NL && c != CH_TAB)
        c = (c > CH_TILDE) ? c - NP_OFFSET : c + NP_OFFSET;
    end
    put(c);
    last_char = c;
    tail = rendered_q.pop_back();
    tail.last = 1'b1;
    rendered_q.push_back(tail);
  endfunction

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 9))
      0: return CH_TAB;
      1: return 8'($urandom_range(0, 31));
      2: return 8'($urandom_range(127, 159));
      3: return 8'($urandom_range(160, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send(input logic [7:0] b, input logic nf);
    in_item_t it;
    int gap;
    it.in_byte = b;
    it.new_file = nf;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    render(it);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rendered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_mode(input cfg_t m);
    drain();
    write_reg(CFG_NUMBER_NONBLANK, m.number_nonblank);
    write_reg(CFG_NUMBER_ALL, m.number_all);
    write_reg(CFG_SQUEEZE_BLANK, m.squeeze_blank);
    write_reg(CFG_SHOW_TABS, m.show_tabs);
    write_reg(CFG_SHOW_NONPRINTING, m.show_nonprinting);
    write_reg(CFG_SHOW_ENDS, m.show_ends);
    // writes to unused indexes must leave the mode alone
    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 1'($urandom_range(0, 1)));
    @(posedge clk);
    cfg_we <= 1'b0;
    mode = m;
  endtask

  task automatic test_render_extremes();
    cfg_t m;
    m = '0;
    m.show_tabs = 1'b1;
    m.show_nonprinting = 1'b1;
    m.show_ends = 1'b1;
    set_mode(m);
    send(8'd0, 1'b1);
    send(8'd31, 1'b0);
    send(CH_DEL, 1'b0);
    send(META_LO, 1'b0);
    send(META_HI, 1'b0);
    send(8'd160, 1'b0);
    send(8'd255, 1'b0);
    send(CH_TAB, 1'b0);
    send(CH_TILDE, 1'b0);
    send(CH_NL, 1'b0);
  endtask

  task automatic test_line_numbers();
    cfg_t m;
    // both numbering modes set, blank line gets padding before the end mark
    m = '0;
    m.number_nonblank = 1'b1;
    m.number_all = 1'b1;
    m.show_ends = 1'b1;
    set_mode(m);
    send(8'h78, 1'b0);
    send(CH_NL, 1'b0);
    send(CH_NL, 1'b0);
    m = '0;
    m.number_all = 1'b1;
    m.squeeze_blank = 1'b1;
    set_mode(m);
    send(CH_NL, 1'b0);
    send(CH_NL, 1'b0);
    send(CH_NL, 1'b0);
    send(CH_NL, 1'b0);
    send(8'h79, 1'b0);
  endtask

  task automatic test_new_file();
    send(CH_NL, 1'b0);
    send(CH_NL, 1'b0);
    send(CH_NL, 1'b1);
    send(8'h61, 1'b0);
    send(8'h62, 1'b1);
    send(CH_NL, 1'b0);
  endtask

  // line numbers run past a decimal carry into a second digit
  task automatic test_counter_carry();
    cfg_t m;
    int k;
    m = '0;
    m.number_all = 1'b1;
    set_mode(m);
    quiet = 1'b1;
    send(CH_NL, 1'b1);
    for (k = 0; k < CARRY_LINES; k++) send(CH_NL, 1'b0);
    m.number_nonblank = 1'b1;
    m.show_ends = 1'b1;
    set_mode(m);
    send(8'h7a, 1'b0);
    send(CH_NL, 1'b0);
    send(CH_NL, 1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_random_text();
    cfg_t m;
    int sent;
    int chunk;
    int len;
    int k;
    sent = 0;
    for (chunk = 0; chunk < 10; chunk++) begin
      if (chunk == 0) m = '1;
      else if (chunk == 1) m = '0;
      else m = cfg_t'(6'($urandom_range(0, 63)));
      set_mode(m);
      quiet = (chunk >= 8) || ($urandom_range(0, 3) == 0);
      while (sent < (chunk + 1) * 21) begin
        if ($urandom_range(0, 9) == 0) begin
          send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = $urandom_range(0, 7);
          for (k = 0; k < len; k++) begin
            send(text_char(), $urandom_range(0, 29) == 0);
            sent++;
          end
          send(CH_NL, 1'b0);
          sent++;
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              send(CH_NL, 1'b0);
              sent++;
            end
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_output
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rendered_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: out_byte %h last %b", out_data.out_byte,
                   out_data.last);
      end else begin
        want = rendered_q.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("out_byte exp %h got %h, last exp %b got %b", want.out_byte,
                     out_data.out_byte, want.last, out_data.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("text_stream_line_filter: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    quiet = 1'b0;
    errors = 0;
    stall_left = 0;
    stuck_cycles = 0;
    mode = '0;
    last_char = CH_NL;
    line_no = 20'd1;
    blank_run = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_render_extremes();
    test_line_numbers();
    test_new_file();
    test_counter_carry();
    test_random_text();
    drain();
    if (errors == 0) begin
      $display("text_stream_line_filter: match");
    end else begin
      $display("text_stream_line_filter: mismatch");
    end
    $finish;
  end

endmodule
